// ----- design/gtsa_pkg.sv -----
// Shared types and constants for the generation-tagged slot allocator.
package gtsa_pkg;

  // Field widths
  localparam int GenW      = 16;
  localparam int SlotNumW  = 16;
  localparam int HandleW   = 32;
  localparam int ModeW     = 2;
  localparam int StatusW   = 2;
  localparam int SlotOutW  = 4;

  // Default table size
  localparam int SlotCountDefault = 16;

  // Operation codes
  localparam logic [ModeW-1:0] ModeAlloc  = 2'd0;
  localparam logic [ModeW-1:0] ModeFree   = 2'd1;
  localparam logic [ModeW-1:0] ModeLookup = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusFull    = 2'd1;
  localparam logic [StatusW-1:0] StatusInvalid = 2'd2;

  // Request beat
  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [HandleW-1:0] handle_in;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [HandleW-1:0]  handle_out;
    logic [StatusW-1:0]  status;
    logic [SlotOutW-1:0] slot_index;
  } rsp_t;

endpackage

// ----- design/gtsa_gen_store.sv -----
// Generation counter memory: registered synchronous read, per-entry valid bits for reset-to-zero.
module gtsa_gen_store #(
  parameter int SLOT_COUNT = gtsa_pkg::SlotCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr_i,
  output logic [gtsa_pkg::GenW-1:0]     rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr_i,
  input  logic [gtsa_pkg::GenW-1:0]     wr_data_i
);

  logic [gtsa_pkg::GenW-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]     written_q;
  logic [gtsa_pkg::GenW-1:0] rd_data_q;
  logic                      rd_written_q;

  // Entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  // Array write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q    <= mem[rd_addr_i];
      rd_written_q <= written_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

// ----- design/generation_tagged_slot_allocator_core.sv -----
// Top level of the generation-tagged slot allocator (generational handle table).
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   operation: allocate, free or lookup, plus a handle for free and lookup.
//   Response channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//   one beat per request, in request order: new handle, status, slot index.
//   A beat moves on an edge where valid is high and stall is low.
// Timing:
//   A request taken in the idle state has its response registered in the execute
//   state that follows, once the output register is free. One request is in
//   flight at a time: the generation memory is read in the accept cycle and
//   written back in the execute state, so a new request is taken only after that.
// Reset:
//   Every slot is free and every generation reads as zero; no clearing pass.
// Backpressure:
//   While a response waits under out_stall_i, the next request can still be
//   accepted and its memory read done; it completes once the output register
//   is free, and in_stall_o stays high until then.
module generation_tagged_slot_allocator_core #(
  parameter int SLOT_COUNT = gtsa_pkg::SlotCountDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gtsa_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gtsa_pkg::rsp_t out_data_o
);

  localparam int IdxW = $clog2(SLOT_COUNT);

  // Sequencer codes
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                           state_q, state_d;
  logic [SLOT_COUNT-1:0]          free_map_q, free_map_d;
  logic [gtsa_pkg::ModeW-1:0]     op_q;
  logic [IdxW-1:0]                slot_q;
  logic                           hit_q;
  logic                           full_q;
  logic [gtsa_pkg::GenW-1:0]      gen_in_q;
  logic                           out_valid_q, out_valid_d;
  gtsa_pkg::rsp_t                 out_data_q, out_data_d;

  logic                           in_fire;
  logic                           exec_fire;
  logic [IdxW-1:0]                lowest_free;
  logic [gtsa_pkg::SlotNumW-1:0]  slot_num;
  logic                           num_in_range;
  logic [IdxW-1:0]                handle_slot;
  logic [IdxW-1:0]                rd_addr;
  logic [gtsa_pkg::GenW-1:0]      gen_rd;
  logic [gtsa_pkg::GenW-1:0]      gen_new;
  logic                           gen_match;
  logic                           gen_wr_en;

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign exec_fire  = (state_q == StExec) && (!out_valid_q || !out_stall_i);

  // Lowest free slot
  always_comb begin
    lowest_free = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_map_q[i]) begin
        lowest_free = IdxW'(i);
      end
    end
  end

  // Decode the handle's slot number
  assign slot_num     = in_data_i.handle_in[gtsa_pkg::SlotNumW-1:0];
  assign num_in_range = (slot_num != '0) &&
                        (slot_num <= gtsa_pkg::SlotNumW'(SLOT_COUNT));
  assign handle_slot  = IdxW'(slot_num - gtsa_pkg::SlotNumW'(1));
  assign rd_addr      = (in_data_i.mode == gtsa_pkg::ModeAlloc) ? lowest_free : handle_slot;

  // Capture the request for the execute cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= in_data_i.mode;
      slot_q   <= rd_addr;
      full_q   <= (free_map_q == '0);
      hit_q    <= num_in_range && !free_map_q[handle_slot];
      gen_in_q <= in_data_i.handle_in[gtsa_pkg::HandleW-1:gtsa_pkg::SlotNumW];
    end
  end

  gtsa_gen_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_gen_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .rd_addr_i(rd_addr),
    .rd_data_o(gen_rd),
    .wr_en_i  (gen_wr_en),
    .wr_addr_i(slot_q),
    .wr_data_i(gen_new)
  );

  assign gen_new   = gen_rd + gtsa_pkg::GenW'(1);
  assign gen_match = hit_q && (gen_rd == gen_in_q);
  assign gen_wr_en = exec_fire && (op_q == gtsa_pkg::ModeAlloc) && !full_q;

  // Execute: form the response and update the free map
  always_comb begin
    free_map_d = free_map_q;
    out_data_d = out_data_q;
    if (exec_fire) begin
      out_data_d.handle_out = '0;
      out_data_d.status     = gtsa_pkg::StatusInvalid;
      out_data_d.slot_index = '0;
      unique case (op_q)
        gtsa_pkg::ModeAlloc: begin
          if (full_q) begin
            out_data_d.status = gtsa_pkg::StatusFull;
          end else begin
            free_map_d[slot_q]    = 1'b0;
            out_data_d.handle_out = {gen_new,
                                     gtsa_pkg::SlotNumW'(slot_q) + gtsa_pkg::SlotNumW'(1)};
            out_data_d.status     = gtsa_pkg::StatusOk;
            out_data_d.slot_index = gtsa_pkg::SlotOutW'(slot_q);
          end
        end
        gtsa_pkg::ModeFree: begin
          if (gen_match) begin
            free_map_d[slot_q]    = 1'b1;
            out_data_d.status     = gtsa_pkg::StatusOk;
            out_data_d.slot_index = gtsa_pkg::SlotOutW'(slot_q);
          end
        end
        gtsa_pkg::ModeLookup: begin
          if (gen_match) begin
            out_data_d.status     = gtsa_pkg::StatusOk;
            out_data_d.slot_index = gtsa_pkg::SlotOutW'(slot_q);
          end
        end
        default: begin
          out_data_d.status = gtsa_pkg::StatusInvalid;
        end
      endcase
    end
  end

  // Sequencer and output valid
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_fire) state_d = StExec;
      StExec: if (exec_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      free_map_q  <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_map_q  <= free_map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A taken request always moves the sequencer into execute
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StExec))
    else $error("request accepted but not executing");

  // A new response only appears out of an execute cycle
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StExec))
    else $error("response without execute");

  // At most one slot is released per cycle
  a_one_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_map_q) <= $countones($past(free_map_q)) + 1)
    else $error("more than one slot released in a cycle");
`endif

endmodule

// ----- tb/sv/slot_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for the slot allocator: mirrors the slot table and compares response beats.
module slot_table_checker #(
  parameter int SLOT_COUNT = gtsa_pkg::SlotCountDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_o,
  input  gtsa_pkg::req_t in_data_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  gtsa_pkg::rsp_t out_data_o,
  output int             fail_count_o,
  output int             owed_count_o
);

  // Mirror of the table: 1 = slot free
  logic [SLOT_COUNT-1:0]       slot_free;
  logic [gtsa_pkg::GenW-1:0]   slot_gen [SLOT_COUNT];

  // Responses still owed by the block, oldest first
  gtsa_pkg::rsp_t owed_rsp [$];
  gtsa_pkg::rsp_t want;

  // Apply one request to the mirror and build the response it must produce
  task automatic predict_slot_op(input gtsa_pkg::req_t r, output gtsa_pkg::rsp_t e);
    logic [gtsa_pkg::SlotNumW-1:0] num;
    logic [gtsa_pkg::GenW-1:0]     tag;
    logic                          hit;
    int                            s;
    e        = '0;
    e.status = gtsa_pkg::StatusInvalid;
    case (r.mode) inside
      gtsa_pkg::ModeAlloc: begin
        if (slot_free == '0) begin
          e.status = gtsa_pkg::StatusFull;
        end else begin
          for (s = 0; s < SLOT_COUNT; s++) if (slot_free[s]) break;
          slot_gen[s]   = slot_gen[s] + 16'd1;   // wraps at 16 bits
          slot_free[s]  = 1'b0;
          e.handle_out  = {slot_gen[s], 16'(s + 1)};
          e.status      = gtsa_pkg::StatusOk;
          e.slot_index  = 4'(s);
        end
      end
      gtsa_pkg::ModeFree, gtsa_pkg::ModeLookup: begin
        num = r.handle_in[15:0];
        tag = r.handle_in[31:16];
        hit = (num != 0) && (num <= SLOT_COUNT);
        s   = 0;
        if (hit) begin
          s   = num - 1;
          hit = !slot_free[s] && (slot_gen[s] == tag);
        end
        if (hit) begin
          if (r.mode == gtsa_pkg::ModeFree) slot_free[s] = 1'b1;
          e.status     = gtsa_pkg::StatusOk;
          e.slot_index = 4'(s);
        end
      end
      default: ;  // unused mode: invalid, no change
    endcase
  endtask

  // Watch both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_free = '1;
      for (int i = 0; i < SLOT_COUNT; i++) slot_gen[i] = '0;
      owed_rsp.delete();
      fail_count_o = 0;
      owed_count_o = 0;
    end else begin
      // response beat: compare against the oldest owed one
      if (out_valid_o && !out_stall_i) begin
        if (owed_rsp.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, actual %h",
                   $time, out_data_o);
          fail_count_o++;
        end else begin
          want = owed_rsp.pop_front();
          if (out_data_o.handle_out !== want.handle_out) begin
            $display("%0t: handle_out mismatch, expected %h actual %h",
                     $time, want.handle_out, out_data_o.handle_out);
            fail_count_o++;
          end
          if (out_data_o.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_data_o.status);
            fail_count_o++;
          end
          if (out_data_o.slot_index !== want.slot_index) begin
            $display("%0t: slot_index mismatch, expected %0d actual %0d",
                     $time, want.slot_index, out_data_o.slot_index);
            fail_count_o++;
          end
        end
      end
      // request beat: predict its response
      if (in_valid_i && !in_stall_o) begin
        predict_slot_op(in_data_i, want);
        owed_rsp.push_back(want);
      end
      owed_count_o = owed_rsp.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the slot allocator: request stimulus, response stalls and verdict.
module tb;

  localparam int SlotCount     = gtsa_pkg::SlotCountDefault;
  localparam int RandomItems   = 1750;
  localparam int WatchdogLimit = 1000;
  localparam int TailCycles    = 10;
  localparam logic [gtsa_pkg::ModeW-1:0] ModeUnused = 2'd3;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  gtsa_pkg::req_t in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  gtsa_pkg::rsp_t out_data_o;

  int fail_count;
  int owed_count;

  // Idle limits per side, changed in stretches
  int in_max  = 5;
  int out_max = 5;

  int reqs_sent   = 0;
  int rsps_seen   = 0;
  int n_ok        = 0;
  int n_full      = 0;
  int n_invalid   = 0;
  int idle_cycles = 0;

  // Every handle the block has granted, oldest first
  logic [gtsa_pkg::HandleW-1:0] granted_handles [$];

  generation_tagged_slot_allocator_core #(
    .SLOT_COUNT(SlotCount)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  slot_table_checker #(
    .SLOT_COUNT(SlotCount)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .fail_count_o(fail_count),
    .owed_count_o(owed_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Send one request beat after a random gap; valid stays high on return
  task automatic send_req(input logic [gtsa_pkg::ModeW-1:0] mode,
                          input logic [gtsa_pkg::HandleW-1:0] handle);
    gtsa_pkg::req_t r;
    int             gap;
    r.mode      = mode;
    r.handle_in = handle;
    gap = $urandom_range(0, in_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    reqs_sent++;
  endtask

  // Handle for free/lookup: mostly granted ones, some stale, some malformed
  function automatic logic [gtsa_pkg::HandleW-1:0] pick_handle();
    logic [gtsa_pkg::HandleW-1:0] h;
    int sel, n, k;
    sel = $urandom_range(0, 99);
    n   = granted_handles.size();
    if (n == 0 || sel >= 85) begin
      case ($urandom_range(0, 4))
        0: h = $urandom();
        1: h = {16'($urandom()), 16'h0000};                            // slot number zero
        2: h = {16'($urandom()), 16'(SlotCount + 1 + $urandom_range(0, 3))};  // past the table
        3: h = {16'($urandom()), 16'hFFFF};
        default: h = {16'($urandom_range(0, 2)), 16'($urandom_range(1, SlotCount))};
      endcase
    end else begin
      // recent grants are most likely still live
      if (sel < 60) k = n - 1 - $urandom_range(0, (n < 16 ? n : 16) - 1);
      else k = $urandom_range(0, n - 1);
      h = granted_handles[k];
      if (sel >= 75) h[31:16] = h[31:16] + 16'($urandom_range(1, 3));  // stale generation
    end
    return h;
  endfunction

  // Response stall: random hold per beat
  initial begin : rsp_stall
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(0, out_max);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Record response beats; sampled mid-cycle, ahead of the edge that takes them
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsps_seen++;
      case (out_data_o.status)
        gtsa_pkg::StatusOk:   n_ok++;
        gtsa_pkg::StatusFull: n_full++;
        default:              n_invalid++;
      endcase
      if (out_data_o.status == gtsa_pkg::StatusOk && out_data_o.handle_out != '0)
        granted_handles.push_back(out_data_o.handle_out);
    end
  end

  // Watchdog: too long without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, WatchdogLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                 i, pick, n, slot;
    logic [SlotCount:0] released;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad handles on an empty table, fill to full, then edge lookups/frees
    send_req(gtsa_pkg::ModeLookup, 32'h0000_0000);
    send_req(gtsa_pkg::ModeFree, {16'd0, 16'd1});                     // slot not busy
    send_req(ModeUnused, 32'hFFFF_FFFF);
    for (i = 0; i < SlotCount; i++) send_req(gtsa_pkg::ModeAlloc, $urandom());
    send_req(gtsa_pkg::ModeAlloc, 32'h0000_0000);                     // table full
    send_req(gtsa_pkg::ModeLookup, {16'd1, 16'(SlotCount)});          // live handle, top slot
    send_req(gtsa_pkg::ModeLookup, {16'd2, 16'(SlotCount)});          // stale generation
    send_req(gtsa_pkg::ModeLookup, {16'd1, 16'(SlotCount + 1)});      // slot number out of range
    send_req(gtsa_pkg::ModeFree, {16'd1, 16'(SlotCount)});
    send_req(gtsa_pkg::ModeFree, {16'd1, 16'(SlotCount)});            // already released

    // Random mix, idling in stretches
    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        in_max  = ($urandom_range(0, 3) == 0) ? 0 : 5;
        out_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) send_req(gtsa_pkg::ModeAlloc, $urandom());
      else if (pick < 70) send_req(gtsa_pkg::ModeFree, pick_handle());
      else if (pick < 95) send_req(gtsa_pkg::ModeLookup, pick_handle());
      else send_req(ModeUnused, $urandom());
    end
    in_valid_i <= 1'b0;
    while (rsps_seen != reqs_sent) @(posedge clk_i);

    // Release the newest grant of each slot so the table ends empty
    released = '0;
    n = granted_handles.size();
    for (i = n - 1; i >= 0; i--) begin
      slot = int'(granted_handles[i][15:0]);
      if (!released[slot]) begin
        released[slot] = 1'b1;
        send_req(gtsa_pkg::ModeFree, granted_handles[i]);
      end
    end
    in_valid_i <= 1'b0;

    // Drain and settle
    while (rsps_seen != reqs_sent || owed_count != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d requests, %0d responses: %0d ok, %0d full, %0d invalid",
             reqs_sent, rsps_seen, n_ok, n_full, n_invalid);
    $display("random mix of %0d ops with stalls on both sides, then every live slot released",
             RandomItems);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
